@@ rtl/uds_pkg.sv @@
// Shared types, constants and codes of the diagnostic responder.
`default_nettype none
package uds_pkg;

   // Receive buffer size; a frame that fills it without completing is dropped.
   localparam int BUFFER_BYTES = 64;
   localparam int FILL_BITS    = $clog2(BUFFER_BYTES + 1);
   // Services only look at the first sixteen frame bytes.
   localparam int STORE_BYTES  = 16;
   localparam int STORE_BITS   = $clog2(STORE_BYTES);

   // Service identifiers and response markers.
   localparam logic [7:0] NEG_MARK     = 8'h7F;
   localparam logic [7:0] POS_ADD      = 8'h40;
   localparam logic [7:0] SVC_SESSION  = 8'h10;
   localparam logic [7:0] SVC_SECURITY = 8'h27;
   localparam logic [7:0] SVC_READ     = 8'h22;
   localparam logic [7:0] SVC_WRITE    = 8'h2E;
   localparam logic [7:0] SVC_RESET    = 8'h11;

   // Sub-functions.
   localparam logic [7:0] SUB_DEFAULT  = 8'h01;
   localparam logic [7:0] SUB_EXTENDED = 8'h03;
   localparam logic [7:0] SUB_SEED     = 8'h01;
   localparam logic [7:0] SUB_KEY      = 8'h02;
   localparam logic [7:0] SUB_HARD     = 8'h01;

   // Negative response codes.
   localparam logic [7:0] NRC_NOT_SUPPORTED = 8'h11;
   localparam logic [7:0] NRC_SUBFN         = 8'h12;
   localparam logic [7:0] NRC_LENGTH        = 8'h13;
   localparam logic [7:0] NRC_CONDITIONS    = 8'h22;
   localparam logic [7:0] NRC_SEQUENCE      = 8'h24;
   localparam logic [7:0] NRC_RANGE         = 8'h31;
   localparam logic [7:0] NRC_DENIED        = 8'h33;
   localparam logic [7:0] NRC_BAD_KEY       = 8'h35;

   // Register map indexes.
   localparam logic [2:0] REG_DID_RUN    = 3'd0;
   localparam logic [2:0] REG_DID_GAINS  = 3'd1;
   localparam logic [2:0] REG_DID_ENC    = 3'd2;
   localparam logic [2:0] REG_DID_LINE   = 3'd3;
   localparam logic [2:0] REG_SEED_OFS   = 3'd4;
   localparam logic [2:0] REG_KEY_MASK   = 3'd5;

   typedef enum logic [1:0] {
      SEC_LOCKED = 2'd0,
      SEC_SEED   = 2'd1,
      SEC_OPEN   = 2'd2
   } sec_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_SEND
   } back_state_type;

   typedef struct packed {
      logic        [7:0]  rx_byte;
      logic        [31:0] tick_now;
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic signed [15:0] line_offset;
   } req_word_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic       save_request;
      logic       restart_request;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] did_run_flag;
      logic [15:0] did_gains;
      logic [15:0] did_encoder;
      logic [15:0] did_line_offset;
      logic [31:0] seed_offset;
      logic [31:0] key_mask;
   } cfg_type;

   // A completed frame handed from the front to the back.
   typedef struct packed {
      logic [STORE_BYTES-1:0][7:0] bytes;
      logic [31:0]                 tick_now;
      logic [31:0]                 left_count;
      logic [31:0]                 right_count;
      logic [15:0]                 line_offset;
   } frame_type;

   // Queue handshake between front and back.
   typedef struct packed {
      logic avail;
   } fq_status_type;

endpackage
`default_nettype wire

@@ rtl/uds_diag_responder.sv @@
// Diagnostic responder: top level with configuration registers.
// A completing request byte queues its frame; the back end executes it and then streams
// its words out. Throughput: one request byte per cycle while full is low; the back end
// emits one word per cycle from its response buffer while its result queue is not full.
// Up to two completed frames queue between front and back.
// Reset is synchronous, active high; registers return to their default values.
`default_nettype none
module uds_diag_responder
   import uds_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   output logic         full,
   input  req_word_type req_word,
   output logic         empty,
   input  wire          pop,
   output rsp_word_type rsp_word,
   input  wire          psel,
   input  wire          penable,
   input  wire          pwrite,
   input  wire  [4:0]   paddr,
   input  wire  [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   cfg_type       cfg_ff;
   fq_status_type fq_status;
   frame_type     fq_frame;
   logic          fq_take, wr_en;
   logic [2:0]    reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[4:2];

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.did_run_flag    <= 16'h0100;
         cfg_ff.did_gains       <= 16'h0101;
         cfg_ff.did_encoder     <= 16'h0102;
         cfg_ff.did_line_offset <= 16'h0103;
         cfg_ff.seed_offset     <= 32'h0000_1234;
         cfg_ff.key_mask        <= 32'h55AA_55AA;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_DID_RUN:   cfg_ff.did_run_flag    <= pwdata[15:0];
            REG_DID_GAINS: cfg_ff.did_gains       <= pwdata[15:0];
            REG_DID_ENC:   cfg_ff.did_encoder     <= pwdata[15:0];
            REG_DID_LINE:  cfg_ff.did_line_offset <= pwdata[15:0];
            REG_SEED_OFS:  cfg_ff.seed_offset     <= pwdata;
            REG_KEY_MASK:  cfg_ff.key_mask        <= pwdata;
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (reg_idx)
         REG_DID_RUN:   prdata = {16'd0, cfg_ff.did_run_flag};
         REG_DID_GAINS: prdata = {16'd0, cfg_ff.did_gains};
         REG_DID_ENC:   prdata = {16'd0, cfg_ff.did_encoder};
         REG_DID_LINE:  prdata = {16'd0, cfg_ff.did_line_offset};
         REG_SEED_OFS:  prdata = cfg_ff.seed_offset;
         REG_KEY_MASK:  prdata = cfg_ff.key_mask;
         default:       prdata = 32'd0;
      endcase
   end

   uds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .fq_status (fq_status),
      .fq_frame  (fq_frame),
      .fq_take   (fq_take)
   );

   uds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fq_status (fq_status),
      .fq_frame  (fq_frame),
      .fq_take   (fq_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

@@ rtl/uds_front.sv @@
// Front end: collects request bytes and queues each completed frame.
`default_nettype none
module uds_front
   import uds_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   output logic         full,
   input  req_word_type req_word,
   output fq_status_type fq_status,
   output frame_type    fq_frame,
   input  wire          fq_take
);

   logic [STORE_BYTES-1:0][7:0] store_ff, store_in;
   logic [FILL_BITS-1:0]        fill_ff, fill_in;
   frame_type                   q_ff [2];
   logic                        wptr_ff, rptr_ff;
   logic [1:0]                  cnt_ff;
   logic                        accept, complete, enq;
   logic [7:0]                  len_byte;
   logic [FILL_BITS-1:0]        fill_next;
   frame_type                   snap;

   assign full   = (cnt_ff == 2'd2);
   assign accept = push && !full;

   // Byte collection and completion check.
   always_comb begin
      store_in = store_ff;
      if (fill_ff < FILL_BITS'(STORE_BYTES)) begin
         store_in[fill_ff[STORE_BITS-1:0]] = req_word.rx_byte;
      end
      len_byte  = store_in[0];
      fill_next = fill_ff + FILL_BITS'(1);
      // The length byte is compared at its full eight bits.
      complete  = (len_byte != 8'd0) && (8'(fill_next) >= len_byte);
      if (complete || fill_next == FILL_BITS'(BUFFER_BYTES)) begin
         fill_in = '0;
      end else begin
         fill_in = fill_next;
      end
      enq                = accept && complete;
      snap.bytes         = store_in;
      snap.tick_now      = req_word.tick_now;
      snap.left_count    = req_word.left_count;
      snap.right_count   = req_word.right_count;
      snap.line_offset   = req_word.line_offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         fill_ff  <= '0;
      end else if (accept) begin
         store_ff <= store_in;
         fill_ff  <= fill_in;
      end
   end

   // Two-entry frame queue toward the back end.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (enq) wptr_ff <= !wptr_ff;
         if (fq_take) rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + 2'(enq) - 2'(fq_take);
      end
   end

   always_ff @(posedge clock) begin
      if (enq) q_ff[wptr_ff] <= snap;
   end

   assign fq_status.avail = (cnt_ff != 2'd0);
   assign fq_frame        = q_ff[rptr_ff];

endmodule
`default_nettype wire

@@ rtl/uds_back.sv @@
// Back end: runs the service of each frame and streams the response words.
`default_nettype none
module uds_back
   import uds_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  cfg_type       cfg,
   input  fq_status_type fq_status,
   input  frame_type     fq_frame,
   output logic          fq_take,
   output logic          empty,
   input  wire           pop,
   output rsp_word_type  rsp_word
);

   back_state_type state_ff, state_in;

   logic                 sess_ff, sess_in;
   sec_type              sec_ff, sec_in;
   logic [31:0]          seed_ff, seed_in;
   logic [7:0]           run_ff, run_in;
   logic [2:0][31:0]     gain_ff, gain_in;

   logic [15:0][7:0]     resp_ff, resp_in;
   logic [4:0]           rlen_ff, rlen_in;
   logic                 rsave_ff, rsave_in, rrest_ff, rrest_in;
   logic [3:0]           idx_ff;

   rsp_word_type         oq_ff [2];
   logic                 owptr_ff, orptr_ff;
   logic [1:0]           ocnt_ff;
   logic                 ofull, opush, opop, last_byte;
   rsp_word_type         oword;

   logic [7:0]           len, sid, sub;
   logic [15:0]          did;
   logic [31:0]          key, seed_new;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (fq_status.avail) state_in = BK_EXEC;
         BK_EXEC: state_in = BK_SEND;
         BK_SEND: if (!ofull && last_byte) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   // Controls derived from the state.
   always_comb begin
      fq_take = 1'b0;
      opush   = 1'b0;
      unique case (state_ff)
         BK_IDLE: ;
         BK_EXEC: fq_take = 1'b1;
         BK_SEND: opush = !ofull;
         default: ;
      endcase
   end

   assign last_byte = ({1'b0, idx_ff} + 5'd1) == rlen_ff;

   // Service execution: builds the response and updates the server state.
   always_comb begin
      len      = fq_frame.bytes[0];
      sid      = fq_frame.bytes[1];
      sub      = fq_frame.bytes[2];
      did      = {fq_frame.bytes[2], fq_frame.bytes[3]};
      key      = {fq_frame.bytes[6], fq_frame.bytes[5], fq_frame.bytes[4],
                  fq_frame.bytes[3]};
      seed_new = fq_frame.tick_now + cfg.seed_offset;
      sess_in  = sess_ff;
      sec_in   = sec_ff;
      seed_in  = seed_ff;
      run_in   = run_ff;
      gain_in  = gain_ff;
      resp_in  = '0;
      resp_in[1] = sid + POS_ADD;
      rlen_in  = 5'd0;
      rsave_in = 1'b0;
      rrest_in = 1'b0;
      case (sid)
         SVC_SESSION: begin
            rlen_in = 5'd3; resp_in[0] = 8'd3; resp_in[2] = sub;
            if (len < 8'd3) begin
               rlen_in = 5'd0; resp_in[3] = NRC_LENGTH;
            end else if (sub == SUB_DEFAULT) begin
               sess_in = 1'b0; sec_in = SEC_LOCKED;
            end else if (sub == SUB_EXTENDED) begin
               sess_in = 1'b1;
            end else begin
               rlen_in = 5'd0; resp_in[3] = NRC_SUBFN;
            end
         end
         SVC_SECURITY: begin
            if (!sess_ff) begin
               resp_in[3] = NRC_CONDITIONS;
            end else if (sub == SUB_SEED) begin
               seed_in = seed_new; sec_in = SEC_SEED;
               rlen_in = 5'd7; resp_in[0] = 8'd7; resp_in[2] = SUB_SEED;
               resp_in[3] = seed_new[7:0];   resp_in[4] = seed_new[15:8];
               resp_in[5] = seed_new[23:16]; resp_in[6] = seed_new[31:24];
            end else if (sub == SUB_KEY) begin
               if (sec_ff != SEC_SEED) begin
                  resp_in[3] = NRC_SEQUENCE;
               end else if (key == (seed_ff ^ cfg.key_mask)) begin
                  sec_in = SEC_OPEN;
                  rlen_in = 5'd3; resp_in[0] = 8'd3; resp_in[2] = SUB_KEY;
               end else begin
                  sec_in = SEC_LOCKED; resp_in[3] = NRC_BAD_KEY;
               end
            end else begin
               resp_in[3] = NRC_SUBFN;
            end
         end
         SVC_READ: begin
            resp_in[2] = fq_frame.bytes[2]; resp_in[3] = fq_frame.bytes[3];
            if (len < 8'd4) begin
               resp_in[3] = NRC_LENGTH;
            end else if (did == cfg.did_run_flag) begin
               rlen_in = 5'd5; resp_in[0] = 8'd5; resp_in[4] = run_ff;
            end else if (did == cfg.did_gains) begin
               rlen_in = 5'd16; resp_in[0] = 8'd16;
               for (int w = 0; w < 3; w++) begin
                  for (int k = 0; k < 4; k++) begin
                     resp_in[4 + 4*w + k] = gain_ff[w][8*k +: 8];
                  end
               end
            end else if (did == cfg.did_encoder) begin
               rlen_in = 5'd12; resp_in[0] = 8'd12;
               for (int k = 0; k < 4; k++) begin
                  resp_in[4 + k] = fq_frame.left_count[8*k +: 8];
                  resp_in[8 + k] = fq_frame.right_count[8*k +: 8];
               end
            end else if (did == cfg.did_line_offset) begin
               rlen_in = 5'd6; resp_in[0] = 8'd6;
               resp_in[4] = fq_frame.line_offset[15:8];
               resp_in[5] = fq_frame.line_offset[7:0];
            end else begin
               resp_in[3] = NRC_RANGE;
            end
         end
         SVC_WRITE: begin
            resp_in[2] = fq_frame.bytes[2]; resp_in[3] = fq_frame.bytes[3];
            resp_in[0] = 8'd4;
            if (sec_ff != SEC_OPEN) begin
               resp_in[3] = NRC_DENIED;
            end else if (did == cfg.did_run_flag) begin
               rlen_in = 5'd4; run_in = fq_frame.bytes[4];
            end else if (did == cfg.did_gains) begin
               if (len < 8'd16) begin
                  resp_in[3] = NRC_LENGTH;
               end else begin
                  rlen_in = 5'd4; rsave_in = 1'b1;
                  for (int w = 0; w < 3; w++) begin
                     gain_in[w] = {fq_frame.bytes[7 + 4*w], fq_frame.bytes[6 + 4*w],
                                   fq_frame.bytes[5 + 4*w], fq_frame.bytes[4 + 4*w]};
                  end
               end
            end else begin
               resp_in[3] = NRC_RANGE;
            end
         end
         SVC_RESET: begin
            if (sub == SUB_HARD) begin
               rlen_in = 5'd3; resp_in[0] = 8'd3; resp_in[2] = SUB_HARD;
               rrest_in = 1'b1;
            end else begin
               resp_in[3] = NRC_SUBFN;
            end
         end
         default: resp_in[3] = NRC_NOT_SUPPORTED;
      endcase
      // A zero length here marks a negative response.
      if (rlen_in == 5'd0) begin
         rlen_in    = 5'd4;
         resp_in[0] = 8'd4;
         resp_in[1] = NEG_MARK;
         resp_in[2] = sid;
         for (int k = 4; k < 16; k++) resp_in[k] = 8'd0;
      end
   end

   // Server state, updated once per frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         sess_ff <= 1'b0;
         sec_ff  <= SEC_LOCKED;
         seed_ff <= '0;
         run_ff  <= '0;
         gain_ff <= '0;
      end else if (state_ff == BK_EXEC) begin
         sess_ff <= sess_in;
         sec_ff  <= sec_in;
         seed_ff <= seed_in;
         run_ff  <= run_in;
         gain_ff <= gain_in;
      end
   end

   // Response buffer and byte index.
   always_ff @(posedge clock) begin
      if (state_ff == BK_EXEC) begin
         resp_ff  <= resp_in;
         rlen_ff  <= rlen_in;
         rsave_ff <= rsave_in;
         rrest_ff <= rrest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)                 idx_ff <= '0;
      else if (state_ff == BK_EXEC) idx_ff <= '0;
      else if (opush)            idx_ff <= idx_ff + 4'd1;
   end

   // Two-entry result queue.
   always_comb begin
      oword.tx_byte         = resp_ff[idx_ff];
      oword.tx_last         = last_byte;
      oword.save_request    = last_byte && rsave_ff;
      oword.restart_request = last_byte && rrest_ff;
   end

   assign ofull = (ocnt_ff == 2'd2);
   assign empty = (ocnt_ff == 2'd0);
   assign opop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         owptr_ff <= 1'b0;
         orptr_ff <= 1'b0;
         ocnt_ff  <= 2'd0;
      end else begin
         if (opush) owptr_ff <= !owptr_ff;
         if (opop)  orptr_ff <= !orptr_ff;
         ocnt_ff <= ocnt_ff + 2'(opush) - 2'(opop);
      end
   end

   always_ff @(posedge clock) begin
      if (opush) oq_ff[owptr_ff] <= oword;
   end

   assign rsp_word = oq_ff[orptr_ff];

endmodule
`default_nettype wire

@@ rtl/uds_checker.sv @@
// Port-level checks of the diagnostic responder, bound to the top level.
`default_nettype none
module uds_port_checks
   import uds_pkg::*;
(
   input wire          clock,
   input wire          reset,
   input wire          empty,
   input wire          pop,
   input rsp_word_type rsp_word
);

   // The save pulse rides only on the final word of a response.
   a_save_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.save_request) |-> rsp_word.tx_last)
      else $error("save request away from last word");

   // The restart pulse rides only on the final word of a response.
   a_restart_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.restart_request) |-> rsp_word.tx_last)
      else $error("restart request away from last word");

   // No response asks for both a save and a restart.
   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_word.save_request && rsp_word.restart_request))
      else $error("save and restart on the same word");

   // The result queue is empty in the first cycle after reset is released.
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> empty)
      else $error("result queue not empty after reset");

   // A waiting word holds until it is popped.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_word)))
      else $error("waiting word changed");

endmodule

bind uds_diag_responder uds_port_checks u_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_word (rsp_word)
);
`default_nettype wire

@@ test/uds_checker.sv @@
// Checker for the diagnostic responder: predicts response words and compares them.
module uds_checker
   import uds_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   input  wire          full,
   input  req_word_type req_word,
   input  wire          empty,
   input  wire          pop,
   input  rsp_word_type rsp_word,
   input  wire          psel,
   input  wire          penable,
   input  wire          pwrite,
   input  wire  [4:0]   paddr,
   input  wire  [31:0]  pwdata,
   input  wire          pready,
   output int           pending,
   output int           errors
);

   // Local copy of the configuration and of the responder state.
   cfg_type     cfg;
   logic        sess_ext;
   sec_type     sec_lvl;
   logic [31:0] seed_val;
   logic [7:0]  rx_store [BUFFER_BYTES];
   int          rx_fill;
   logic [7:0]  stored_run;
   logic [31:0] gain [3];

   // Response words still to come, oldest first.
   rsp_word_type expected_words [$];

   assign pending = expected_words.size();

   function automatic logic [7:0] frame_at(int i);
      return (i < BUFFER_BYTES) ? rx_store[i] : 8'h00;
   endfunction

   function automatic logic [31:0] frame_le32(int i);
      return {frame_at(i + 3), frame_at(i + 2), frame_at(i + 1), frame_at(i)};
   endfunction

   // Runs the service of a completed frame and queues its response words.
   function automatic void answer_frame(req_word_type w);
      logic [7:0]  r [16];
      logic [7:0]  len, sid, sub, code;
      logic [15:0] did;
      int          n;
      bit          save, restart;
      rsp_word_type o;
      len = frame_at(0);
      sid = frame_at(1);
      sub = frame_at(2);
      did = {frame_at(2), frame_at(3)};
      foreach (r[i]) r[i] = 8'h00;
      r[1] = sid + POS_ADD;
      n = 0;
      code = 8'h00;
      save = 0;
      restart = 0;
      case (sid)
         SVC_SESSION: begin
            if (len < 3) code = NRC_LENGTH;
            else if (sub == SUB_DEFAULT) begin
               sess_ext = 0;
               sec_lvl = SEC_LOCKED;
            end else if (sub == SUB_EXTENDED) sess_ext = 1;
            else code = NRC_SUBFN;
            r[0] = 8'd3; r[2] = sub; n = 3;
         end
         SVC_SECURITY: begin
            if (!sess_ext) code = NRC_CONDITIONS;
            else if (sub == SUB_SEED) begin
               seed_val = w.tick_now + cfg.seed_offset;
               sec_lvl = SEC_SEED;
               r[0] = 8'd7; r[2] = SUB_SEED;
               {r[6], r[5], r[4], r[3]} = seed_val;
               n = 7;
            end else if (sub == SUB_KEY) begin
               if (sec_lvl != SEC_SEED) code = NRC_SEQUENCE;
               else if (frame_le32(3) == (seed_val ^ cfg.key_mask)) begin
                  sec_lvl = SEC_OPEN;
                  r[0] = 8'd3; r[2] = SUB_KEY; n = 3;
               end else begin
                  sec_lvl = SEC_LOCKED;
                  code = NRC_BAD_KEY;
               end
            end else code = NRC_SUBFN;
         end
         SVC_READ: begin
            r[2] = frame_at(2); r[3] = frame_at(3);
            if (len < 4) code = NRC_LENGTH;
            else if (did == cfg.did_run_flag) begin
               r[0] = 8'd5; r[4] = stored_run; n = 5;
            end else if (did == cfg.did_gains) begin
               r[0] = 8'd16;
               {r[7], r[6], r[5], r[4]} = gain[0];
               {r[11], r[10], r[9], r[8]} = gain[1];
               {r[15], r[14], r[13], r[12]} = gain[2];
               n = 16;
            end else if (did == cfg.did_encoder) begin
               r[0] = 8'd12;
               {r[7], r[6], r[5], r[4]} = w.left_count;
               {r[11], r[10], r[9], r[8]} = w.right_count;
               n = 12;
            end else if (did == cfg.did_line_offset) begin
               r[0] = 8'd6;
               {r[4], r[5]} = w.line_offset;
               n = 6;
            end else code = NRC_RANGE;
         end
         SVC_WRITE: begin
            r[0] = 8'd4; r[2] = frame_at(2); r[3] = frame_at(3); n = 4;
            if (sec_lvl != SEC_OPEN) code = NRC_DENIED;
            else if (did == cfg.did_run_flag) stored_run = frame_at(4);
            else if (did == cfg.did_gains) begin
               if (len < 16) code = NRC_LENGTH;
               else begin
                  gain[0] = frame_le32(4);
                  gain[1] = frame_le32(8);
                  gain[2] = frame_le32(12);
                  save = 1;
               end
            end else code = NRC_RANGE;
         end
         SVC_RESET: begin
            if (sub == SUB_HARD) begin
               r[0] = 8'd3; r[2] = SUB_HARD; n = 3; restart = 1;
            end else code = NRC_SUBFN;
         end
         default: code = NRC_NOT_SUPPORTED;
      endcase
      // A negative response replaces whatever the service had built.
      if (code != 8'h00) begin
         r[0] = 8'd4; r[1] = NEG_MARK; r[2] = sid; r[3] = code;
         n = 4; save = 0; restart = 0;
      end
      for (int k = 0; k < n; k++) begin
         o.tx_byte = r[k];
         o.tx_last = (k == n - 1);
         o.save_request = (k == n - 1) && save;
         o.restart_request = (k == n - 1) && restart;
         expected_words.push_back(o);
      end
   endfunction

   // Collects one request word into the frame store.
   function automatic void take_byte(req_word_type w);
      if (rx_fill >= BUFFER_BYTES) rx_fill = 0;
      rx_store[rx_fill] = w.rx_byte;
      rx_fill++;
      if (rx_store[0] != 8'h00 && rx_fill >= rx_store[0]) begin
         answer_frame(w);
         rx_fill = 0;
      end else if (rx_fill >= BUFFER_BYTES) rx_fill = 0;
   endfunction

   // Everything is sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         cfg.did_run_flag <= 16'h0100;
         cfg.did_gains <= 16'h0101;
         cfg.did_encoder <= 16'h0102;
         cfg.did_line_offset <= 16'h0103;
         cfg.seed_offset <= 32'h0000_1234;
         cfg.key_mask <= 32'h55AA_55AA;
         sess_ext = 0;
         sec_lvl = SEC_LOCKED;
         seed_val = '0;
         foreach (rx_store[i]) rx_store[i] = 8'h00;
         rx_fill = 0;
         stored_run = 8'h00;
         foreach (gain[i]) gain[i] = '0;
         expected_words.delete();
         errors <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_DID_RUN:   cfg.did_run_flag <= pwdata[15:0];
               REG_DID_GAINS: cfg.did_gains <= pwdata[15:0];
               REG_DID_ENC:   cfg.did_encoder <= pwdata[15:0];
               REG_DID_LINE:  cfg.did_line_offset <= pwdata[15:0];
               REG_SEED_OFS:  cfg.seed_offset <= pwdata;
               REG_KEY_MASK:  cfg.key_mask <= pwdata;
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (expected_words.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected response word %h", $realtime, rsp_word);
               errors <= errors + 1;
            end else begin
               want = expected_words.pop_front();
               if (rsp_word !== want) begin
                  if (errors < 10)
                     $display("%0t: word mismatch byte %h/%h last %b/%b save %b/%b restart %b/%b",
                              $realtime, want.tx_byte, rsp_word.tx_byte,
                              want.tx_last, rsp_word.tx_last,
                              want.save_request, rsp_word.save_request,
                              want.restart_request, rsp_word.restart_request);
                  errors <= errors + 1;
               end
            end
         end
         if (push && !full) take_byte(req_word);
      end
   end

endmodule

@@ test/tb_uds_diag_responder.sv @@
// Testbench top for the diagnostic responder: clock, reset, stimulus and verdict.
module tb_uds_diag_responder;
   import uds_pkg::*;

   typedef enum int {
      K_SESS_DEF, K_SESS_EXT, K_SESS_BAD, K_SESS_SHORT, K_SEED, K_KEY_OK, K_KEY_BAD,
      K_SEC_BAD, K_RD_RUN, K_RD_GAIN, K_RD_ENC, K_RD_LINE, K_RD_BAD, K_RD_SHORT,
      K_WR_RUN, K_WR_GAIN, K_WR_GAIN_SHORT, K_WR_BAD, K_RESET, K_RESET_BAD,
      K_UNKNOWN, K_TINY, K_NOISE, K_ZERO, K_OVERSIZE, K_LONG
   } frame_kind_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         push = 0;
   logic         full;
   req_word_type req_word = '0;
   logic         empty;
   logic         pop = 0;
   rsp_word_type rsp_word;
   logic         psel = 0;
   logic         penable = 0;
   logic         pwrite = 0;
   logic [4:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;
   int           pending;
   int           errors;

   // What the sender knows to build valid keys and identifiers.
   logic [15:0]  did_list [4] = '{16'h0100, 16'h0101, 16'h0102, 16'h0103};
   logic [31:0]  seed_ofs = 32'h0000_1234;
   logic [31:0]  mask = 32'h55AA_55AA;
   logic [31:0]  last_seed = '0;
   int           stall_asks = 0;
   int           stall_done = 0;
   int           stall_left = 0;

   uds_diag_responder dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   uds_checker check (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
      .pending(pending), .errors(errors)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Receiver: random pops, occasional holds, and long holds on request.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         pop = 0;
         stall_left--;
      end else if (stall_asks != stall_done) begin
         stall_done++;
         stall_left = 300;
         pop = 0;
      end else if ($urandom_range(0, 49) == 0) begin
         stall_left = $urandom_range(5, 40);
         pop = 0;
      end else begin
         pop = ($urandom_range(0, 9) < 8);
      end
   end

   // Offers one word and holds it until accepted, then, unless no_gap is set, sometimes idles a random while.
   task automatic send_byte(logic [7:0] b, logic [31:0] tick, bit no_gap);
      int roll;
      req_word.rx_byte = b;
      req_word.tick_now = tick;
      req_word.left_count = $urandom;
      req_word.right_count = $urandom;
      req_word.line_offset = $urandom;
      push = 1;
      do @(posedge clock); while (full);
      @(negedge clock);
      roll = $urandom_range(0, 99);
      if (!no_gap && roll >= 60) begin
         push = 0;
         repeat (roll < 92 ? $urandom_range(1, 3) : $urandom_range(5, 40))
            @(negedge clock);
      end
   endtask

   task automatic send_frame(frame_kind_type kind, bit burst);
      logic [7:0]  f [$];
      logic [31:0] tick;
      logic [31:0] key;
      logic [15:0] did;
      int          len;
      tick = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
      case (kind)
         K_SESS_DEF:   f = '{8'd3, SVC_SESSION, SUB_DEFAULT};
         K_SESS_EXT:   f = '{8'd3, SVC_SESSION, SUB_EXTENDED};
         K_SESS_BAD:   f = '{8'd3, SVC_SESSION, 8'($urandom_range(4, 255))};
         K_SESS_SHORT: f = '{8'd2, SVC_SESSION};
         K_SEED: begin
            f = '{8'd3, SVC_SECURITY, SUB_SEED};
            last_seed = tick + seed_ofs;
         end
         K_KEY_OK: begin
            key = last_seed ^ mask;
            f = '{8'd7, SVC_SECURITY, SUB_KEY, key[7:0], key[15:8], key[23:16], key[31:24]};
         end
         K_KEY_BAD: begin
            key = (last_seed ^ mask) ^ (32'd1 << $urandom_range(0, 31));
            f = '{8'd7, SVC_SECURITY, SUB_KEY, key[7:0], key[15:8], key[23:16], key[31:24]};
         end
         K_SEC_BAD:    f = '{8'd3, SVC_SECURITY, 8'($urandom_range(3, 255))};
         K_RD_RUN, K_RD_GAIN, K_RD_ENC, K_RD_LINE: begin
            did = did_list[kind - K_RD_RUN];
            f = '{8'd4, SVC_READ, did[15:8], did[7:0]};
         end
         K_RD_BAD: f = '{8'd4, SVC_READ, 8'($urandom), 8'($urandom)};
         K_RD_SHORT: f = '{8'd3, SVC_READ, 8'h01};
         K_WR_RUN: f = '{8'd5, SVC_WRITE, did_list[0][15:8], did_list[0][7:0], 8'($urandom)};
         K_WR_GAIN, K_WR_GAIN_SHORT: begin
            len = (kind == K_WR_GAIN) ? $urandom_range(16, 20) : $urandom_range(5, 15);
            f = '{8'(len), SVC_WRITE, did_list[1][15:8], did_list[1][7:0]};
            while (f.size() < len) f.push_back(8'($urandom));
         end
         K_WR_BAD: f = '{8'd5, SVC_WRITE, did_list[2][15:8], did_list[2][7:0], 8'($urandom)};
         K_RESET:     f = '{8'd3, SVC_RESET, SUB_HARD};
         K_RESET_BAD: f = '{8'd3, SVC_RESET, 8'($urandom_range(2, 255))};
         K_UNKNOWN:   f = '{8'd3, 8'hFF, 8'h00};
         K_TINY:      f = '{8'd1};
         K_NOISE: begin
            len = $urandom_range(1, 20);
            f = '{8'(len)};
            while (f.size() < len) f.push_back(8'($urandom));
         end
         K_ZERO, K_OVERSIZE: begin
            // Never completes; the whole buffer is filled and dropped.
            f = '{(kind == K_ZERO) ? 8'd0 : 8'($urandom_range(BUFFER_BYTES + 1, 255))};
            while (f.size() < BUFFER_BYTES) f.push_back(8'($urandom));
         end
         K_LONG: begin
            len = ($urandom_range(0, 3) == 0) ? BUFFER_BYTES : $urandom_range(17, 40);
            f = '{8'(len), SVC_READ, did_list[3][15:8], did_list[3][7:0]};
            while (f.size() < len) f.push_back(8'($urandom));
         end
         default: f = '{8'd1};
      endcase
      foreach (f[i]) send_byte(f[i], tick, burst);
   endtask

   // Writes one register while the block is idle.
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      push = 0;
      wait (pending == 0);
      repeat (20) @(negedge clock);
      psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = value;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      case (idx)
         REG_DID_RUN:   did_list[0] = value[15:0];
         REG_DID_GAINS: did_list[1] = value[15:0];
         REG_DID_ENC:   did_list[2] = value[15:0];
         REG_DID_LINE:  did_list[3] = value[15:0];
         REG_SEED_OFS:  seed_ofs = value;
         REG_KEY_MASK:  mask = value;
         default: ;
      endcase
   endtask

   task automatic random_frames(int count);
      int   roll;
      bit   burst;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         burst = ($urandom_range(0, 3) == 0);
         if (roll < 25) begin
            // Unlock sequence followed by a write or read.
            send_frame(K_SESS_EXT, burst);
            send_frame(K_SEED, burst);
            send_frame(($urandom_range(0, 4) == 0) ? K_KEY_BAD : K_KEY_OK, burst);
            send_frame(frame_kind_type'($urandom_range(K_RD_RUN, K_WR_BAD)), burst);
         end else if (roll < 88) begin
            send_frame(frame_kind_type'($urandom_range(K_SESS_DEF, K_TINY)), burst);
         end else if (roll < 97) begin
            send_frame(K_NOISE, burst);
         end else begin
            send_frame(($urandom_range(0, 1) == 0) ? K_LONG : K_OVERSIZE, burst);
         end
      end
   endtask

   // Run time limit.
   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: every service in its good and bad forms.
      send_frame(K_UNKNOWN, 0);
      send_frame(K_TINY, 0);
      send_frame(K_SEED, 0);
      send_frame(K_WR_RUN, 0);
      send_frame(K_SESS_SHORT, 0);
      send_frame(K_SESS_BAD, 0);
      send_frame(K_SESS_EXT, 0);
      send_frame(K_KEY_OK, 0);
      send_frame(K_SEC_BAD, 0);
      send_frame(K_SEED, 0);
      send_frame(K_KEY_BAD, 0);
      send_frame(K_SEED, 0);
      send_frame(K_SEED, 0);
      send_frame(K_KEY_OK, 0);
      send_frame(K_WR_RUN, 0);
      send_frame(K_WR_GAIN_SHORT, 0);
      send_frame(K_WR_GAIN, 0);
      send_frame(K_WR_BAD, 0);
      send_frame(K_RD_RUN, 0);
      for (int k = K_RD_ENC; k <= K_RD_SHORT; k++) send_frame(frame_kind_type'(k), 0);
      send_frame(K_RESET, 0);
      send_frame(K_RESET_BAD, 0);
      send_frame(($urandom_range(0, 1) == 0) ? K_ZERO : K_OVERSIZE, 0);
      send_frame(K_SESS_DEF, 0);

      // Fill the block while the receiver holds off.
      stall_asks++;
      for (int i = 0; i < 4; i++) send_frame(K_RD_GAIN, 1);

      // Extreme settings, with two identifiers colliding.
      csr_write(REG_DID_RUN, 32'h0000_0000);
      csr_write(REG_DID_GAINS, 32'hFFFF_FFFF);
      csr_write(REG_DID_ENC, 32'h0000_FFFF);
      csr_write(REG_DID_LINE, 32'h0000_0000);
      csr_write(REG_SEED_OFS, 32'hFFFF_FFFF);
      csr_write(REG_KEY_MASK, 32'h0000_0000);
      random_frames(3);

      // Random settings.
      for (int k = REG_DID_RUN; k <= REG_KEY_MASK; k++) csr_write(3'(k), $urandom);
      stall_asks++;
      random_frames(3);

      push = 0;
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/uds_pkg.sv
rtl/uds_front.sv
rtl/uds_back.sv
rtl/uds_diag_responder.sv
rtl/uds_checker.sv
test/uds_checker.sv
test/tb_uds_diag_responder.sv
